### rtl/core/six_register_ip_bound_machine_top_macros.svh
// Assertion macros shared by the register machine RTL.
`ifndef SIX_REGISTER_IP_BOUND_MACHINE_TOP_MACROS_SVH
`define SIX_REGISTER_IP_BOUND_MACHINE_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SRM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("register machine check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("register machine sequencing check failed");

`endif

### rtl/core/srm_pkg.sv
// Shared constants, opcode codes and types of the register machine.
`timescale 1ns / 1ps
package srm_pkg;

  localparam int unsigned RegCount  = 6;
  localparam int unsigned RegIdxW   = $clog2(RegCount);
  localparam int unsigned DataW     = 64;
  localparam int unsigned HalfW     = DataW / 2;
  localparam int unsigned OperandW  = 24;
  localparam int unsigned OpcodeW   = 4;
  localparam int unsigned DestW     = 3;
  localparam int unsigned PtrSelW   = 3;
  localparam int unsigned ProgLenW  = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 11;

  typedef enum logic [OpcodeW-1:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PTR_REG  = 1'd0,
    CFG_PROG_LEN = 1'd1
  } cfg_idx_e;

  // Index checks reported by the register file for one transaction
  typedef struct packed {
    logic ptr_ok;
    logic a_ok;
    logic b_ok;
    logic dest_ok;
  } idx_status_t;

  // First operand comes from the register file
  function automatic logic op_a_is_reg(op_e op);
    logic r;
    case (op)
      OP_SETI, OP_GTIR, OP_EQIR: r = 1'b0;
      default:                   r = 1'b1;
    endcase
    return r;
  endfunction

  // Second operand comes from the register file
  function automatic logic op_b_is_reg(op_e op);
    logic r;
    case (op)
      OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
      OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: r = 1'b1;
      default:                            r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/six_register_ip_bound_machine_top.sv
// Top level of the register machine with an instruction-pointer-bound register.
//
// Input channel (in_*): one instruction per transaction (opcode, two operands,
// destination register). Output channel (out_*): one result per instruction
// (next pointer, value written, halted and bad-index flags). Both channels
// use valid/stall; a transaction completes when valid is high and stall low.
// Configuration (cfg_*): write-only port, index 0 selects the register bound
// to the instruction pointer, index 1 sets the program length. Write it only
// while no instruction is in flight.
// An accepted instruction is held in the instruction register; execute moves
// its result into the result register when the output is not stalled, where
// the receiver takes it. One instruction per cycle while the output is not
// stalled; the execute pass from the instruction register through the register
// file, the split 64-bit multiply and the pointer update into the result
// register sets this, since each instruction sees the previous one's state.
// Reset clears the register file, the instruction pointer, both configuration
// registers and all valid flags. When the receiver stalls, the result register
// holds; the instruction register still fills, then in_stall_o rises.
`timescale 1ns / 1ps
`include "six_register_ip_bound_machine_top_macros.svh"
module six_register_ip_bound_machine_top import srm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  // instruction channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OpcodeW-1:0]       in_opcode_i,
  input  logic [OperandW-1:0]      in_first_operand_i,
  input  logic [OperandW-1:0]      in_second_operand_i,
  input  logic [DestW-1:0]         in_dest_register_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DataW-1:0]  out_next_pointer_o,
  output logic signed [DataW-1:0]  out_written_value_o,
  output logic                     out_halted_o,
  output logic                     out_bad_index_o
);

  logic [PtrSelW-1:0]  ptr_sel_q;
  logic [ProgLenW-1:0] prog_len_q;

  logic                in_valid_q;
  logic                in_valid_d;
  op_e                 op_q;
  logic [OperandW-1:0] a_q;
  logic [OperandW-1:0] b_q;
  logic [DestW-1:0]    dest_q;

  logic                out_valid_q;
  logic                out_valid_d;
  logic [DataW-1:0]    next_ptr_q;
  logic [DataW-1:0]    res_q;
  logic                halted_q;
  logic                bad_q;

  logic                in_accept;
  logic                exec_fire;
  logic                a_reg;
  logic                b_reg;
  logic [DataW-1:0]    a_rd;
  logic [DataW-1:0]    b_rd;
  logic [DataW-1:0]    a_val;
  logic [DataW-1:0]    b_val;
  logic [DataW-1:0]    res;
  logic [DataW-1:0]    next_ptr;
  logic                halted;
  logic                bad;
  idx_status_t         status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_sel_q  <= '0;
      prog_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PTR_REG:  ptr_sel_q  <= cfg_wdata_i[PtrSelW-1:0];
        CFG_PROG_LEN: prog_len_q <= cfg_wdata_i[ProgLenW-1:0];
        default:      ;
      endcase
    end
  end

  // Handshake: execute moves the instruction register into the result register
  assign exec_fire   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !exec_fire;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_accept || (in_valid_q && !exec_fire);
  assign out_valid_d = exec_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Instruction register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_e'(in_opcode_i);
      a_q    <= in_first_operand_i;
      b_q    <= in_second_operand_i;
      dest_q <= in_dest_register_i;
    end
  end

  // Operand source decode
  assign a_reg = op_a_is_reg(op_q);
  assign b_reg = op_b_is_reg(op_q);

  srm_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (exec_fire),
    .ptr_sel_i  (ptr_sel_q),
    .a_idx_i    (a_q),
    .b_idx_i    (b_q),
    .dest_i     (dest_q),
    .res_i      (res),
    .a_data_o   (a_rd),
    .b_data_o   (b_rd),
    .next_ptr_o (next_ptr),
    .status_o   (status)
  );

  // Immediates are zero-extended
  assign a_val = a_reg ? a_rd : DataW'(a_q);
  assign b_val = b_reg ? b_rd : DataW'(b_q);

  srm_alu u_alu (
    .op_i  (op_q),
    .a_i   (a_val),
    .b_i   (b_val),
    .res_o (res)
  );

  // Status flags
  assign halted = next_ptr[DataW-1] || (next_ptr >= DataW'(prog_len_q));
  assign bad    = !status.ptr_ok || !status.dest_ok ||
                  (a_reg && !status.a_ok) || (b_reg && !status.b_ok);

  // Result register
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      next_ptr_q <= next_ptr;
      res_q      <= res;
      halted_q   <= halted;
      bad_q      <= bad;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_next_pointer_o  = next_ptr_q;
  assign out_written_value_o = res_q;
  assign out_halted_o        = halted_q;
  assign out_bad_index_o     = bad_q;

  // Checks
  `SRM_ASSERT_NEXT(a_exec_fills_out, exec_fire, out_valid_q)
  `SRM_ASSERT(a_empty_no_stall, !in_valid_q |-> !in_stall_o)
  `SRM_ASSERT(a_zero_len_halts, (out_valid_q && (prog_len_q == '0)) |-> out_halted_o)
  `SRM_ASSERT_NEXT(a_bad_ptr_sel, exec_fire && !status.ptr_ok, out_bad_index_o)

endmodule

### rtl/core/srm_alu.sv
// Combinational execute unit: arithmetic, logic, set and compare operations.
`timescale 1ns / 1ps
module srm_alu import srm_pkg::*; (
  input  op_e               op_i,
  input  logic [DataW-1:0]  a_i,
  input  logic [DataW-1:0]  b_i,
  output logic [DataW-1:0]  res_o
);

  logic [DataW-1:0] prod_lo;
  logic [HalfW-1:0] cross_ab;
  logic [HalfW-1:0] cross_ba;
  logic [DataW-1:0] prod;
  logic             gt;
  logic             eq;

  // Low half of the 64x64 product from three 32x32 partial products
  assign prod_lo  = a_i[HalfW-1:0] * b_i[HalfW-1:0];
  assign cross_ab = HalfW'(a_i[HalfW-1:0] * b_i[DataW-1:HalfW]);
  assign cross_ba = HalfW'(a_i[DataW-1:HalfW] * b_i[HalfW-1:0]);
  assign prod     = prod_lo + {cross_ab + cross_ba, {HalfW{1'b0}}};

  // Signed compares
  assign gt = $signed(a_i) > $signed(b_i);
  assign eq = a_i == b_i;

  // Result select
  always_comb begin
    case (op_i)
      OP_ADDR, OP_ADDI:          res_o = a_i + b_i;
      OP_MULR, OP_MULI:          res_o = prod;
      OP_BANR, OP_BANI:          res_o = a_i & b_i;
      OP_BORR, OP_BORI:          res_o = a_i | b_i;
      OP_SETR, OP_SETI:          res_o = a_i;
      OP_GTIR, OP_GTRI, OP_GTRR: res_o = {{(DataW-1){1'b0}}, gt};
      default:                   res_o = {{(DataW-1){1'b0}}, eq};
    endcase
  end

endmodule

### rtl/core/srm_regs.sv
// Register file and instruction pointer with the pointer-bound register.
`timescale 1ns / 1ps
module srm_regs import srm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [PtrSelW-1:0]  ptr_sel_i,
  input  logic [OperandW-1:0] a_idx_i,
  input  logic [OperandW-1:0] b_idx_i,
  input  logic [DestW-1:0]    dest_i,
  input  logic [DataW-1:0]    res_i,
  output logic [DataW-1:0]    a_data_o,
  output logic [DataW-1:0]    b_data_o,
  output logic [DataW-1:0]    next_ptr_o,
  output idx_status_t         status_o
);

  logic [DataW-1:0] rf_q [RegCount];
  logic [DataW-1:0] rf_d [RegCount];
  logic [DataW-1:0] eff  [RegCount];
  logic [DataW-1:0] ip_q;
  logic [DataW-1:0] bound_val;
  logic             ptr_ok;
  logic             a_ok;
  logic             b_ok;
  logic             dest_ok;

  // Index range checks
  assign ptr_ok  = 32'(ptr_sel_i) < RegCount;
  assign a_ok    = 32'(a_idx_i) < RegCount;
  assign b_ok    = 32'(b_idx_i) < RegCount;
  assign dest_ok = 32'(dest_i) < RegCount;

  assign status_o = '{ptr_ok: ptr_ok, a_ok: a_ok, b_ok: b_ok, dest_ok: dest_ok};

  // File as seen after the pointer preload
  always_comb begin
    for (int i = 0; i < RegCount; i++) begin
      if (ptr_ok && (ptr_sel_i[RegIdxW-1:0] == RegIdxW'(i))) begin
        eff[i] = ip_q;
      end else begin
        eff[i] = rf_q[i];
      end
    end
  end

  // Operand reads, invalid index reads as zero
  assign a_data_o = a_ok ? eff[a_idx_i[RegIdxW-1:0]] : '0;
  assign b_data_o = b_ok ? eff[b_idx_i[RegIdxW-1:0]] : '0;

  // Bound register (zero for an invalid pointer select) after the destination write, then plus one
  always_comb begin
    if (!ptr_ok) begin
      bound_val = '0;
    end else if (dest_ok && (dest_i == ptr_sel_i)) begin
      bound_val = res_i;
    end else begin
      bound_val = ip_q;
    end
  end

  assign next_ptr_o = bound_val + DataW'(1);

  // Next file contents: destination write wins over the pointer preload
  always_comb begin
    for (int i = 0; i < RegCount; i++) begin
      if (dest_ok && (dest_i[RegIdxW-1:0] == RegIdxW'(i))) begin
        rf_d[i] = res_i;
      end else begin
        rf_d[i] = eff[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        rf_q[i] <= '0;
      end
      ip_q <= '0;
    end else if (wr_en_i) begin
      for (int i = 0; i < RegCount; i++) begin
        rf_q[i] <= rf_d[i];
      end
      ip_q <= next_ptr_o;
    end
  end

endmodule
